// ===== sv/sws_pkg.sv =====
// ============================================================================
// sws_pkg
// Shared types and codes for the LIFO stack with linear search.
// ============================================================================
package sws_pkg;

    localparam int SWS_DEPTH = 16;   // default stack depth
    localparam int SWS_DW    = 32;   // stored word width
    localparam int SWS_PW    = 7;    // position field width

    // operation codes
    localparam logic [1:0] MODE_PUSH   = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;

    // result status codes
    localparam logic [2:0] ST_PUSHED    = 3'd0;
    localparam logic [2:0] ST_POPPED    = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [SWS_DW-1:0] value;
    } t_in;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [SWS_DW-1:0] data;
        logic [SWS_PW-1:0]        position;
        logic                     last;
    } t_out;

endpackage

// ===== sv/sws_ram.sv =====
// ============================================================================
// sws_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module sws_ram
    import sws_pkg::*;
#(
    parameter int DEPTH = SWS_DEPTH,
    parameter int AW    = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic signed [SWS_DW-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic signed [SWS_DW-1:0] o_rdata
);

    logic signed [SWS_DW-1:0] r_mem [DEPTH];
    logic signed [SWS_DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/stack_with_search.sv =====
// ============================================================================
// stack_with_search
// Bounded LIFO stack of signed words with a bottom-to-top linear search.
// ============================================================================
//
//   channel   ports                      handshake
//   -------   ------------------------   ------------------------------------
//   command   i_in (mode, value)         taken when i_start && !o_busy
//   result    o_out (status, data,       one word per o_valid cycle, no stall
//             position, last)
//
// Push, and any command that fails at once, is decided in S_IDLE; o_busy stays low.
// Pop goes through S_POP: one RAM read, then the result.
// Search holds o_busy through S_SEARCH, one RAM read per stored entry through
// the single read port, then through S_FLUSH to emit the final word.
// Results appear on the cycle after the decision that produces them.
// Reset clears the state, fill count, match flag and valid; stale RAM contents are never read.
//
module stack_with_search
    import sws_pkg::*;
#(
    parameter int DEPTH = SWS_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_in,
    output logic o_busy,
    output logic o_valid,
    output t_out o_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_POP, S_SEARCH, S_FLUSH} t_state;

    t_state                   r_state, n_state;
    logic [FW-1:0]            r_fill, n_fill;
    logic [FW-1:0]            r_cidx, n_cidx;
    logic signed [SWS_DW-1:0] r_key, n_key;
    logic                     r_have, n_have;
    logic signed [SWS_DW-1:0] r_hdata, n_hdata;
    logic [SWS_PW-1:0]        r_hpos, n_hpos;
    logic                     r_valid, n_valid;
    t_out                     r_out, n_out;

    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic [AW-1:0]            w_raddr;
    logic signed [SWS_DW-1:0] w_rdata;
    logic                     w_full;
    logic                     w_empty;
    logic [FW-1:0]            w_top;

    sws_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in.value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_full  = (r_fill == FW'(DEPTH));
    assign w_empty = (r_fill == '0);
    assign w_top   = FW'(r_fill - 1'b1);

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_cidx  = r_cidx;
        n_key   = r_key;
        n_have  = r_have;
        n_hdata = r_hdata;
        n_hpos  = r_hpos;
        n_valid = 1'b0;
        n_out   = r_out;
        w_we    = 1'b0;
        w_waddr = r_fill[AW-1:0];
        w_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_in.mode)
                        MODE_PUSH: begin
                            n_valid = 1'b1;
                            n_out   = '0;
                            n_out.last = 1'b1;
                            if (w_full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                w_we   = 1'b1;
                                n_fill = FW'(r_fill + 1'b1);
                                n_out.status = ST_PUSHED;
                            end
                        end
                        MODE_POP: begin
                            if (w_empty) begin
                                n_valid = 1'b1;
                                n_out   = '0;
                                n_out.status = ST_EMPTY;
                                n_out.last   = 1'b1;
                            end else begin
                                n_fill  = w_top;
                                w_raddr = w_top[AW-1:0];
                                n_state = S_POP;
                            end
                        end
                        MODE_SEARCH: begin
                            if (w_empty) begin
                                n_valid = 1'b1;
                                n_out   = '0;
                                n_out.status = ST_EMPTY;
                                n_out.last   = 1'b1;
                            end else begin
                                n_key   = i_in.value;
                                n_cidx  = '0;
                                n_have  = 1'b0;
                                n_state = S_SEARCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_POP: begin
                n_valid = 1'b1;
                n_out   = '0;
                n_out.status = ST_POPPED;
                n_out.data   = w_rdata;
                n_out.last   = 1'b1;
                n_state = S_IDLE;
            end
            S_SEARCH: begin
                // w_rdata holds entry r_cidx; fetch the next one meanwhile
                if (r_cidx != w_top) begin
                    n_cidx  = FW'(r_cidx + 1'b1);
                    w_raddr = n_cidx[AW-1:0];
                end else begin
                    n_state = S_FLUSH;
                end
                if (w_rdata == r_key) begin
                    // release the previous match, hold this one until the end
                    if (r_have) begin
                        n_valid = 1'b1;
                        n_out.status   = ST_FOUND;
                        n_out.data     = r_hdata;
                        n_out.position = r_hpos;
                        n_out.last     = 1'b0;
                    end
                    n_have  = 1'b1;
                    n_hdata = w_rdata;
                    n_hpos  = SWS_PW'(SWS_PW'(r_cidx) + 1'b1);
                end
            end
            S_FLUSH: begin
                n_valid = 1'b1;
                n_out   = '0;
                n_out.last = 1'b1;
                if (r_have) begin
                    n_out.status   = ST_FOUND;
                    n_out.data     = r_hdata;
                    n_out.position = r_hpos;
                end else begin
                    n_out.status = ST_NOT_FOUND;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_have  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_have  <= n_have;
            r_valid <= n_valid;
        end
        r_cidx  <= n_cidx;
        r_key   <= n_key;
        r_hdata <= n_hdata;
        r_hpos  <= n_hpos;
        r_out   <= n_out;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_out   = r_out;

    // ------------------------------------------------------------------------
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill count beyond depth");

    a_found_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out.status == ST_FOUND) |->
            (o_out.position != '0) && (o_out.position <= SWS_PW'(r_fill)))
        else $error("found position outside stored entries");

    a_push_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && (i_in.mode == MODE_PUSH) |=>
            o_valid && o_out.last &&
            ((o_out.status == ST_PUSHED) || (o_out.status == ST_FULL)))
        else $error("push without single reply");

    a_scan_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) && $past(r_state == S_SEARCH) && o_valid |->
            !o_out.last)
        else $error("last word emitted mid-scan");

endmodule

// ===== tb/stack_with_search_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// stack_with_search_tb
// Self-checking bench for the LIFO stack with linear search: a shadow stack
// predicts every result word of each command, and a monitor compares each
// strobed word in order. Covers empty and full stacks, extreme values,
// multiple matches, the ignored opcode and long random push/pop/search runs.
// ============================================================================
module stack_with_search_tb;
    import sws_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 250;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_start;
    t_in  i_in;
    logic o_busy;
    logic o_valid;
    t_out o_out;

    stack_with_search dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_in   (i_in),
        .o_busy (o_busy),
        .o_valid(o_valid),
        .o_out  (o_out)
    );

    always #1 i_clk = ~i_clk;

    // shadow of the stack contents
    logic signed [SWS_DW-1:0] shadow_words [SWS_DEPTH];
    int   shadow_fill;
    t_out awaited_words [$];

    int err_count;
    int cycle_count;
    int burst_left;
    int n_push, n_pop, n_search, n_ignored, n_full_hits, n_empty_hits;
    int n_found, n_words_checked, max_fill;
    logic signed [SWS_DW-1:0] value_pool [4];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        err_count++;
    endtask

    // Work out the result words of one accepted command and update the shadow.
    task automatic predict_stack_op(input t_in cmd);
        t_out w;
        t_out hits [$];
        w = '0;
        w.last = 1'b1;
        case (cmd.mode)
            MODE_PUSH: begin
                n_push++;
                if (shadow_fill >= SWS_DEPTH) begin
                    w.status = ST_FULL;
                    n_full_hits++;
                end else begin
                    shadow_words[shadow_fill] = cmd.value;
                    shadow_fill++;
                    if (shadow_fill > max_fill) max_fill = shadow_fill;
                    w.status = ST_PUSHED;
                end
                awaited_words.push_back(w);
            end
            MODE_POP: begin
                n_pop++;
                if (shadow_fill == 0) begin
                    w.status = ST_EMPTY;
                    n_empty_hits++;
                end else begin
                    shadow_fill--;
                    w.status = ST_POPPED;
                    w.data   = shadow_words[shadow_fill];
                end
                awaited_words.push_back(w);
            end
            MODE_SEARCH: begin
                n_search++;
                if (shadow_fill == 0) begin
                    w.status = ST_EMPTY;
                    n_empty_hits++;
                    awaited_words.push_back(w);
                end else begin
                    for (int i = 0; i < shadow_fill; i++) begin
                        if (shadow_words[i] == cmd.value) begin
                            w.status   = ST_FOUND;
                            w.data     = shadow_words[i];
                            w.position = SWS_PW'(i + 1);
                            w.last     = 1'b0;
                            hits.push_back(w);
                        end
                    end
                    if (hits.size() == 0) begin
                        w.status = ST_NOT_FOUND;
                        awaited_words.push_back(w);
                    end else begin
                        n_found += hits.size();
                        hits[hits.size()-1].last = 1'b1;
                        foreach (hits[k]) awaited_words.push_back(hits[k]);
                    end
                end
            end
            default: n_ignored++;
        endcase
    endtask

    // Mostly short gaps, a few long ones, and bursts with no gaps at all.
    function automatic int next_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Hold start until the command is taken, then idle for a random gap.
    task automatic send_word(input logic [1:0] mode, input logic signed [31:0] value);
        t_in cmd;
        int  gap;
        cmd.mode  = mode;
        cmd.value = value;
        i_start <= 1'b1;
        i_in    <= cmd;
        do @(posedge i_clk); while (o_busy);
        predict_stack_op(cmd);
        gap = next_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (awaited_words.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 9) < 6) return value_pool[$urandom_range(0, 3)];
        return $urandom;
    endfunction

    // Search keys mostly hit something already stored.
    function automatic logic signed [31:0] pick_key();
        if (shadow_fill > 0 && $urandom_range(0, 9) < 6)
            return shadow_words[$urandom_range(0, shadow_fill - 1)];
        return pick_value();
    endfunction

    task automatic test_empty_stack();
        send_word(MODE_POP, 32'sd0);
        send_word(MODE_SEARCH, 32'sd0);
        send_word(MODE_UNUSED, 32'hFFFF_FFFF);
        send_word(MODE_POP, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_extreme_values();
        send_word(MODE_PUSH, 32'h8000_0000);
        send_word(MODE_PUSH, 32'h7FFF_FFFF);
        send_word(MODE_PUSH, 32'sd0);
        send_word(MODE_PUSH, -32'sd1);
        send_word(MODE_PUSH, -32'sd1);
        send_word(MODE_SEARCH, -32'sd1);
        send_word(MODE_SEARCH, 32'h8000_0000);
        send_word(MODE_SEARCH, 32'h1234_5678);
        send_word(MODE_POP, 32'sd0);
        send_word(MODE_POP, 32'sd0);
        send_word(MODE_SEARCH, -32'sd1);
        send_word(MODE_POP, 32'sd0);
        send_word(MODE_SEARCH, 32'h7FFF_FFFF);
        wait_drained();
    endtask

    // Fill with one key so a search returns a word for every entry.
    task automatic test_uniform_full();
        logic signed [31:0] key;
        key = $urandom;
        while (shadow_fill > 0) send_word(MODE_POP, $urandom);
        repeat (SWS_DEPTH) send_word(MODE_PUSH, key);
        send_word(MODE_PUSH, ~key);
        send_word(MODE_SEARCH, key);
        send_word(MODE_SEARCH, ~key);
        repeat (SWS_DEPTH + 1) send_word(MODE_POP, $urandom);
        wait_drained();
    endtask

    // Alternate filling and draining phases so fill swings between its ends.
    task automatic test_random_traffic();
        int   sent;
        int   r;
        bit   filling;
        sent    = 0;
        filling = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 40 == 0) begin
                value_pool[0] = $urandom;
                value_pool[1] = $urandom;
                value_pool[2] = 32'h8000_0000;
                value_pool[3] = $urandom_range(0, 3);
            end
            if (filling && shadow_fill == SWS_DEPTH && $urandom_range(0, 2) == 0)
                filling = 1'b0;
            else if (!filling && shadow_fill == 0 && $urandom_range(0, 2) == 0)
                filling = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_word(MODE_UNUSED, $urandom);
            end else begin
                r = $urandom_range(0, 99);
                if (r < (filling ? 60 : 15))
                    send_word(MODE_PUSH, pick_value());
                else if (r < 75)
                    send_word(MODE_POP, $urandom);
                else
                    send_word(MODE_SEARCH, pick_key());
                sent++;
            end
            if ($urandom_range(0, 99) < 2) wait_drained();
        end
        wait_drained();
    endtask

    // Compare each strobed word with the oldest prediction.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid) begin
            n_words_checked++;
            if (awaited_words.size() == 0) begin
                report_mismatch("unexpected word status", 32'(o_out.status), 32'd0);
            end else begin
                want = awaited_words.pop_front();
                if (o_out.status !== want.status)
                    report_mismatch("status", 32'(o_out.status), 32'(want.status));
                if (o_out.data !== want.data)
                    report_mismatch("data", o_out.data, want.data);
                if (o_out.position !== want.position)
                    report_mismatch("position", 32'(o_out.position), 32'(want.position));
                if (o_out.last !== want.last)
                    report_mismatch("last", 32'(o_out.last), 32'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words outstanding", $time, awaited_words.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        err_count       = 0;
        cycle_count     = 0;
        burst_left      = 0;
        shadow_fill     = 0;
        max_fill        = 0;
        n_push          = 0;
        n_pop           = 0;
        n_search        = 0;
        n_ignored       = 0;
        n_full_hits     = 0;
        n_empty_hits    = 0;
        n_found         = 0;
        n_words_checked = 0;
        foreach (value_pool[k]) value_pool[k] = $urandom;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_in    <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_stack();
        test_extreme_values();
        test_random_traffic();
        test_uniform_full();

        repeat (2 * SWS_DEPTH + 8) @(posedge i_clk);
        if (awaited_words.size() != 0)
            report_mismatch("words never seen", awaited_words.size(), 32'd0);

        $display("Ran %0d pushes, %0d pops, %0d searches, %0d ignored opcodes; peak depth %0d",
                 n_push, n_pop, n_search, n_ignored, max_fill);
        $display("Checked %0d words: %0d matches, %0d full, %0d empty; %0d mismatches",
                 n_words_checked, n_found, n_full_hits, n_empty_hits, err_count);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
